>>> hdl/mrfc_pkg.sv
// shared types, codes and the crc step for the meter response frame checker
package mrfc_pkg;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_ARM  = 2'd2;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT    = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_DEVICE_ERROR = 3'd1;
  localparam logic [2:0] ST_FUNC_MISMATCH = 3'd2;
  localparam logic [2:0] ST_CRC_ERROR    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN      = 3'd4;
  localparam logic [2:0] ST_TIMEOUT_RETRY = 3'd5;
  localparam logic [2:0] ST_TIMEOUT_FAIL = 3'd6;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_STATUS  = 1'b1;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  MIN_FRAME = 8'd10;
  localparam logic [7:0]  PAYLOAD_START = 8'd6;
  localparam logic [7:0]  TICK_MAX = 8'd255;

  localparam logic [31:0] RST_DEVICE_ADDRESS = 32'd0;
  localparam logic [7:0]  RST_TIMEOUT_TICKS  = 8'd100;
  localparam logic [3:0]  RST_RETRY_LIMIT    = 4'd3;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TICK,
    OP_ARM
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  rx_byte;
    logic [15:0] request_number;
    logic [7:0]  expected_function;
    logic        reload_retries;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [2:0]  status;
    logic [7:0]  device_error_code;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/mrfc_item_if.sv
// input item channel
interface mrfc_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  rx_byte;
  logic [15:0] request_number;
  logic [7:0]  expected_function;
  logic        reload_retries;

  modport source (output valid, output mode, output rx_byte, output request_number,
                  output expected_function, output reload_retries, input ready);
  modport sink (input valid, input mode, input rx_byte, input request_number,
                input expected_function, input reload_retries, output ready);
endinterface

>>> hdl/mrfc_result_if.sv
// result item channel
interface mrfc_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [2:0] status;
  logic [7:0] device_error_code;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output status, output device_error_code, input ready);
  modport sink (input valid, input kind, input payload_byte, input payload_index,
                input status, input device_error_code, output ready);
endinterface

>>> hdl/mrfc_cfg_if.sv
// configuration write channel
interface mrfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/meter_response_frame_checker_core.sv
// top level of the meter response frame checker
// Checks one reply frame per arm: address bytes, echoed request number, a reflected
// CRC-16 (init 0xFFFF, poly 0xA001) and the function byte, passing payload bytes out
// as they arrive and reporting one final status per frame or timeout. Items are taken
// at one per cycle; each item of modes 0 to 2 goes through a short entry queue to the
// back end, whose state update (one byte-wide crc step) sets that rate; a result is
// held in the back end's result register. While a result waits to be taken the back
// end holds, so the input stalls once the entry queue is full. Mode 3 items are consumed
// with no effect. Configuration writes are taken outside reset and belong in idle periods.
module meter_response_frame_checker_core
  import mrfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  mrfc_item_if.sink     items,
  mrfc_result_if.source results,
  mrfc_cfg_if.sink      cfg
);

  logic   q_full;
  logic   q_push;
  entry_t q_push_entry;
  logic   q_pop;
  logic   q_valid;
  entry_t q_pop_entry;

  mrfc_front u_front (
    .rst     (rst),
    .items   (items),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_push_entry)
  );

  mrfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_pop_entry)
  );

  mrfc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_pop_entry),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .results (results)
  );

endmodule

>>> hdl/mrfc_front.sv
// front end: accepts input items and classifies them into queue entries
module mrfc_front
  import mrfc_pkg::*;
(
  input  logic        rst,
  mrfc_item_if.sink   items,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic accepted;
  logic dropped;

  assign items.ready = !q_full && !rst;
  assign accepted = items.valid && items.ready;

  always_comb begin
    q_entry.rx_byte = items.rx_byte;
    q_entry.request_number = items.request_number;
    q_entry.expected_function = items.expected_function;
    q_entry.reload_retries = items.reload_retries;
    q_entry.op = OP_BYTE;
    dropped = 1'b0;
    unique case (items.mode)
      MODE_BYTE: q_entry.op = OP_BYTE;
      MODE_TICK: q_entry.op = OP_TICK;
      MODE_ARM:  q_entry.op = OP_ARM;
      default:   dropped = 1'b1;
    endcase
  end

  // unused mode is consumed here and never reaches the back end
  assign q_push = accepted && !dropped;

endmodule

>>> hdl/mrfc_queue.sv
// small entry queue between front and back end
module mrfc_queue
  import mrfc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   pop_valid,
  output entry_t pop_entry
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [IW-1:0]   wr_ptr;
  logic [IW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/mrfc_back.sv
// back end: frame state, crc, timeout, configuration and result register
module mrfc_back
  import mrfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        q_pop,
  mrfc_cfg_if.sink    cfg,
  mrfc_result_if.source results
);

  logic [31:0] device_address;
  logic [7:0]  timeout_ticks;
  logic [3:0]  retry_limit;

  logic        waiting, waiting_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic        address_match, address_match_next;
  logic        request_match, request_match_next;
  logic [7:0]  function_seen, function_seen_next;
  logic [7:0]  error_code_seen, error_code_seen_next;
  logic [7:0]  received_crc_low, received_crc_low_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [3:0]  retries_left, retries_left_next;
  logic [15:0] armed_request, armed_request_next;
  logic [7:0]  armed_function, armed_function_next;

  logic        out_valid;
  result_t     out_res;
  logic        res_valid;
  result_t     res;

  logic [7:0]  b;
  logic [8:0]  p9;
  logic [8:0]  len9;
  logic [7:0]  want;
  logic [15:0] crc_step;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= RST_DEVICE_ADDRESS;
      timeout_ticks <= RST_TIMEOUT_TICKS;
      retry_limit <= RST_RETRY_LIMIT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DEVICE_ADDRESS: device_address <= cfg.data;
        CFG_TIMEOUT_TICKS:  timeout_ticks <= cfg.data[7:0];
        CFG_RETRY_LIMIT:    retry_limit <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  assign q_pop = q_valid && (!out_valid || results.ready);

  assign b = q_entry.rx_byte;
  assign p9 = {1'b0, byte_count};
  assign len9 = {1'b0, frame_length};
  assign crc_step = crc_byte(running_crc, b);

  always_comb begin
    unique case (byte_count[1:0])
      2'd0: want = device_address[31:24];
      2'd1: want = device_address[23:16];
      2'd2: want = device_address[15:8];
      default: want = device_address[7:0];
    endcase
  end

  always_comb begin
    waiting_next = waiting;
    byte_count_next = byte_count;
    frame_length_next = frame_length;
    running_crc_next = running_crc;
    address_match_next = address_match;
    request_match_next = request_match;
    function_seen_next = function_seen;
    error_code_seen_next = error_code_seen;
    received_crc_low_next = received_crc_low;
    tick_count_next = tick_count;
    retries_left_next = retries_left;
    armed_request_next = armed_request;
    armed_function_next = armed_function;
    res_valid = 1'b0;
    res = '0;
    res.kind = KIND_STATUS;
    if (q_pop) begin
      unique case (q_entry.op)
        OP_ARM: begin
          waiting_next = 1'b1;
          byte_count_next = '0;
          frame_length_next = '0;
          running_crc_next = CRC_INIT;
          address_match_next = 1'b1;
          request_match_next = 1'b1;
          function_seen_next = '0;
          error_code_seen_next = '0;
          received_crc_low_next = '0;
          tick_count_next = '0;
          armed_request_next = q_entry.request_number;
          armed_function_next = q_entry.expected_function;
          if (q_entry.reload_retries) begin
            retries_left_next = retry_limit;
          end
        end
        OP_TICK: begin
          if (waiting) begin
            tick_count_next = (tick_count != TICK_MAX) ? tick_count + 1'b1 : tick_count;
            if (tick_count_next >= timeout_ticks) begin
              res_valid = 1'b1;
              waiting_next = 1'b0;
              if (retries_left != '0) begin
                retries_left_next = retries_left - 1'b1;
                res.status = ST_TIMEOUT_RETRY;
              end else begin
                res.status = ST_TIMEOUT_FAIL;
              end
            end
          end
        end
        OP_BYTE: begin
          if (waiting) begin
            byte_count_next = byte_count + 1'b1;
            priority if (byte_count < 8'd4) begin
              if (b != want) begin
                address_match_next = 1'b0;
              end
              running_crc_next = crc_step;
            end else if (byte_count == 8'd4) begin
              function_seen_next = b;
              running_crc_next = crc_step;
            end else if (byte_count == 8'd5) begin
              frame_length_next = b;
              running_crc_next = crc_step;
              if (b < MIN_FRAME) begin
                res_valid = 1'b1;
                waiting_next = 1'b0;
                res.status = ST_UNKNOWN;
              end
            end else begin
              if (byte_count == PAYLOAD_START) begin
                error_code_seen_next = b;
              end
              if (p9 + 9'd2 < len9) begin
                running_crc_next = crc_step;
              end
              priority if (p9 + 9'd4 < len9) begin
                res_valid = 1'b1;
                res.kind = KIND_PAYLOAD;
                res.payload_byte = b;
                res.payload_index = byte_count - PAYLOAD_START;
              end else if (p9 + 9'd4 == len9) begin
                if (b != armed_request[15:8]) begin
                  request_match_next = 1'b0;
                end
              end else if (p9 + 9'd3 == len9) begin
                if (b != armed_request[7:0]) begin
                  request_match_next = 1'b0;
                end
              end else if (p9 + 9'd2 == len9) begin
                received_crc_low_next = b;
              end else begin
                res_valid = 1'b1;
                waiting_next = 1'b0;
                priority if (!address_match || !request_match) begin
                  res.status = ST_UNKNOWN;
                end else if (received_crc_low != running_crc[7:0] ||
                             b != running_crc[15:8]) begin
                  res.status = ST_CRC_ERROR;
                end else if (function_seen == armed_function) begin
                  res.status = ST_OK;
                end else if (function_seen == 8'd0) begin
                  res.status = ST_DEVICE_ERROR;
                  res.device_error_code = error_code_seen;
                end else begin
                  res.status = ST_FUNC_MISMATCH;
                end
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting <= 1'b0;
      byte_count <= '0;
      frame_length <= '0;
      running_crc <= CRC_INIT;
      address_match <= 1'b1;
      request_match <= 1'b1;
      function_seen <= '0;
      error_code_seen <= '0;
      received_crc_low <= '0;
      tick_count <= '0;
      retries_left <= RST_RETRY_LIMIT;
      armed_request <= '0;
      armed_function <= '0;
      out_valid <= 1'b0;
    end else begin
      waiting <= waiting_next;
      byte_count <= byte_count_next;
      frame_length <= frame_length_next;
      running_crc <= running_crc_next;
      address_match <= address_match_next;
      request_match <= request_match_next;
      function_seen <= function_seen_next;
      error_code_seen <= error_code_seen_next;
      received_crc_low <= received_crc_low_next;
      tick_count <= tick_count_next;
      retries_left <= retries_left_next;
      armed_request <= armed_request_next;
      armed_function <= armed_function_next;
      if (q_pop) begin
        out_valid <= res_valid;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_res <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.kind = out_res.kind;
  assign results.payload_byte = out_res.payload_byte;
  assign results.payload_index = out_res.payload_index;
  assign results.status = out_res.status;
  assign results.device_error_code = out_res.device_error_code;

endmodule

>>> hdl/mrfc_checker.sv
// port-level assertions for the meter response frame checker, bound to the top level
module mrfc_checker
  import mrfc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] payload_byte,
  input logic [7:0] payload_index,
  input logic [2:0] status,
  input logic [7:0] device_error_code
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte) &&
    $stable(payload_index) && $stable(status) && $stable(device_error_code))
    else $error("stalled result changed");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PAYLOAD |-> status == ST_OK && device_error_code == 8'd0)
    else $error("payload transfer carries status fields");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> payload_byte == 8'd0 && payload_index == 8'd0 &&
    status != 3'd7)
    else $error("status transfer carries payload fields");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DEVICE_ERROR |-> device_error_code == 8'd0)
    else $error("error code without device error");

endmodule

bind meter_response_frame_checker_core mrfc_checker u_mrfc_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .kind              (results.kind),
  .payload_byte      (results.payload_byte),
  .payload_index     (results.payload_index),
  .status            (results.status),
  .device_error_code (results.device_error_code)
);
